// ===== src/sdg_pkg.sv =====
`timescale 1ns / 1ps

package sdg_pkg;

	localparam int OpW      = 3;
	localparam int ValW     = 32;
	localparam int InTdataW = 40;  // op + value, padded to bytes
	localparam int OutTdataW = 72; // 68 bits of result, padded to bytes
	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 10;

	// serial divider operand widths: 60e6 needs 26 bits, 1023*256 fits in 18
	localparam int DivNumW = 26;
	localparam int DivDenW = 18;

	localparam logic [DivNumW-1:0] TicksPerMin = 26'd60000000;
	localparam logic [15:0]        SpeedMax    = 16'hFFFF;

	localparam logic [9:0] SprRst       = 10'd200;
	localparam logic [8:0] MsrRst       = 9'd50;
	localparam logic [7:0] RampStartRst = 8'd210;
	localparam logic [5:0] RampDivRst   = 6'd3;
	localparam logic [7:0] RampMinRst   = 8'd5;
	localparam logic [DivDenW-1:0] ProdRst = 18'd10000;

	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_MOVE_REL  = 3'd1,
		OP_MOVE_ABS  = 3'd2,
		OP_RUN       = 3'd3,
		OP_STOP      = 3'd4,
		OP_SET_POS   = 3'd5,
		OP_SET_SPEED = 3'd6,
		OP_RAMP      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_MOVE = 2'd1,
		MODE_RUN  = 2'd2,
		MODE_RAMP = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		CFG_SPR       = 3'd0,
		CFG_MSR       = 3'd1,
		CFG_DIR_INV   = 3'd2,
		CFG_RAMP_START = 3'd3,
		CFG_RAMP_DIV  = 3'd4,
		CFG_RAMP_MIN  = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DSEL_RAMP = 2'd0, // ramp_index / ramp_divisor
		DSEL_PRE  = 2'd1, // ticks per minute / microsteps per rev
		DSEL_SPD  = 2'd2  // previous quotient / new speed
	} div_sel_t;

	typedef struct packed {
		logic     capture;
		logic     exec;
		logic     move_apply;
		logic     ramp_chk;
		logic     div_start;
		div_sel_t div_sel;
		logic     spd_load;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic go_move;
		logic go_ramp;
		logic go_speed;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

// ===== src/stepper_step_dir_generator_top.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata: op[2:0], value[34:3]
// m_*      out  m_tvalid/m_tready  m_tdata: step_pulse, dir_level, position,
//                                  remaining, busy_res, speed_error
// cfg_*    in   cfg_we             cfg_addr register index, cfg_wdata value
//
// Ticks and plain commands pass capture, execute and finish; moves add an apply step.
// A divider pass yields 26 quotient bits, one per cycle. A speed change takes two
// passes; a ramp start or step: one pass and a check, two more if it lowers speed.
// Reset loads the configuration and axis state at once; no clearing pass.
// A finished result waits in the output register while the next item is
// taken; only the following result waits for it to drain.
module stepper_step_dir_generator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // op[2:0], value[34:3], zero[39:35]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // step_pulse[0], dir_level[1], position[33:2],
	                               // remaining[65:34], busy_res[66], speed_error[67],
	                               // zero[71:68]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [9:0]  cfg_wdata
);

	sdg_pkg::cmd_t cmd;
	sdg_pkg::sts_t sts;

	sdg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	sdg_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (s_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata)
	);

endmodule

// ===== src/sdg_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle; den must be nonzero
module sdg_div #(
	parameter int NumW = sdg_pkg::DivNumW,
	parameter int DenW = sdg_pkg::DivDenW
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NumW-1:0] num,
	input  logic [DenW-1:0] den,
	output logic [NumW-1:0] quo,
	output logic            done
);

	localparam int CntW = $clog2(NumW);

	logic [DenW-1:0] rem_q;
	logic [DenW-1:0] den_q;
	logic [NumW-1:0] quo_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [DenW:0]   trial;
	logic [DenW:0]   diff;
	logic            take;

	assign trial = {rem_q, quo_q[NumW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(NumW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= take ? diff[DenW-1:0] : trial[DenW-1:0];
			quo_q <= {quo_q[NumW-2:0], take};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// ===== src/sdg_dp.sv =====
`timescale 1ns / 1ps

module sdg_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sdg_pkg::cmd_t                      cmd,
	output sdg_pkg::sts_t                      sts,
	input  logic [sdg_pkg::InTdataW-1:0]       in_data,
	input  logic                               cfg_we,
	input  logic [sdg_pkg::CfgAddrW-1:0]       cfg_addr,
	input  logic [sdg_pkg::CfgDataW-1:0]       cfg_wdata,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [sdg_pkg::OutTdataW-1:0]      out_data
);

	localparam int NumW = sdg_pkg::DivNumW;
	localparam int DenW = sdg_pkg::DivDenW;

	// configuration
	logic [9:0] spr_q;
	logic [8:0] msr_q;
	logic       inv_q;
	logic [7:0] rstart_q;
	logic [5:0] rdiv_q;
	logic [7:0] rmin_q;
	logic [DenW-1:0] p_q;

	// axis state
	sdg_pkg::op_t   op_q;
	logic [31:0]    val_q;
	logic [31:0]    pos_q;
	logic [31:0]    steps_q;
	logic           dir_q;
	logic [15:0]    speed_q;
	logic [31:0]    interval_q;
	logic [31:0]    elapsed_q;
	sdg_pkg::mode_t mode_q;
	logic [7:0]     ridx_q;
	logic           pulse_q;
	logic           err_q;
	logic           out_valid_q;

	logic [32:0]    diff_q;
	logic [15:0]    new_spd_q;
	logic [sdg_pkg::OutTdataW-1:0] out_data_q;

	logic [18:0]     prod;
	logic [31:0]     e_inc;
	logic            fire;
	logic            ramp_end;
	logic            sval_pos;
	logic [15:0]     spd_sat;
	logic [7:0]      rpm_lo;
	logic [7:0]      rpm;
	logic [32:0]     diff_neg;
	logic [31:0]     mag;
	logic [32:0]     sub_b;
	logic            div_start;
	logic [NumW-1:0] div_num;
	logic [DenW-1:0] div_den;
	logic [NumW-1:0] div_quo;
	logic            div_done;

	assign prod = 19'(spr_q) * 19'(msr_q);

	assign e_inc    = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
	assign fire     = (mode_q != sdg_pkg::MODE_IDLE) && (speed_q != '0) && (e_inc >= interval_q);
	assign ramp_end = (speed_q < {8'd0, rmin_q}) || (ridx_q == '0);

	assign sval_pos = !val_q[31] && (val_q != '0);
	assign spd_sat  = (|val_q[30:16]) ? sdg_pkg::SpeedMax : val_q[15:0];

	// ramp quotient never exceeds 255
	assign rpm_lo = (div_quo[7:0] < rmin_q) ? rmin_q : div_quo[7:0];
	assign rpm    = (rpm_lo == '0) ? 8'd1 : rpm_lo;

	assign sub_b    = (op_q == sdg_pkg::OP_MOVE_ABS) ? {pos_q[31], pos_q} : '0;
	assign diff_neg = -diff_q;
	assign mag      = diff_q[32] ? diff_neg[31:0] : diff_q[31:0];

	assign sts.go_move  = (op_q == sdg_pkg::OP_MOVE_REL) || (op_q == sdg_pkg::OP_MOVE_ABS);
	assign sts.go_ramp  = ((op_q == sdg_pkg::OP_TICK) && fire && (mode_q == sdg_pkg::MODE_RAMP)
	                       && !ramp_end)
	                   || ((op_q == sdg_pkg::OP_RAMP) && (speed_q != '0) && (rstart_q != '0));
	assign sts.go_speed = cmd.ramp_chk ? (speed_q > {8'd0, rpm})
	                    : ((op_q == sdg_pkg::OP_SET_SPEED) && sval_pos && (spd_sat != speed_q));
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;

	always_comb begin
		div_start = cmd.div_start;
		case (cmd.div_sel)
			sdg_pkg::DSEL_RAMP: begin
				div_num = NumW'(ridx_q);
				div_den = (rdiv_q == '0) ? DenW'(1) : DenW'(rdiv_q);
			end
			sdg_pkg::DSEL_SPD: begin
				div_num = div_quo;
				div_den = DenW'(new_spd_q);
			end
			default: begin
				div_num = sdg_pkg::TicksPerMin;
				div_den = p_q;
			end
		endcase
	end

	sdg_div #(
		.NumW(NumW),
		.DenW(DenW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.quo   (div_quo),
		.done  (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q       <= sdg_pkg::SprRst;
			msr_q       <= sdg_pkg::MsrRst;
			inv_q       <= 1'b0;
			rstart_q    <= sdg_pkg::RampStartRst;
			rdiv_q      <= sdg_pkg::RampDivRst;
			rmin_q      <= sdg_pkg::RampMinRst;
			p_q         <= sdg_pkg::ProdRst;
			op_q        <= sdg_pkg::OP_TICK;
			val_q       <= '0;
			pos_q       <= '0;
			steps_q     <= '0;
			dir_q       <= 1'b0;
			speed_q     <= '0;
			interval_q  <= '1;
			elapsed_q   <= '1;
			mode_q      <= sdg_pkg::MODE_IDLE;
			ridx_q      <= '0;
			pulse_q     <= 1'b0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					sdg_pkg::CFG_SPR:        spr_q    <= cfg_wdata;
					sdg_pkg::CFG_MSR:        msr_q    <= cfg_wdata[8:0];
					sdg_pkg::CFG_DIR_INV:    inv_q    <= cfg_wdata[0];
					sdg_pkg::CFG_RAMP_START: rstart_q <= cfg_wdata[7:0];
					sdg_pkg::CFG_RAMP_DIV:   rdiv_q   <= cfg_wdata[5:0];
					sdg_pkg::CFG_RAMP_MIN:   rmin_q   <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			// a zero product behaves as one
			p_q <= (prod == '0) ? DenW'(1) : prod[DenW-1:0];

			if (cmd.capture) begin
				op_q  <= sdg_pkg::op_t'(in_data[2:0]);
				val_q <= in_data[34:3];
			end

			if (cmd.exec) begin
				pulse_q <= 1'b0;
				err_q   <= 1'b0;
				case (op_q)
					sdg_pkg::OP_TICK: begin
						elapsed_q <= fire ? '0 : e_inc;
						if (fire) begin
							pulse_q <= 1'b1;
							pos_q   <= dir_q ? pos_q + 32'd1 : pos_q - 32'd1;
							if (steps_q != '0)
								steps_q <= steps_q - 32'd1;
							if (mode_q == sdg_pkg::MODE_MOVE && steps_q <= 32'd1)
								mode_q <= sdg_pkg::MODE_IDLE;
							if (mode_q == sdg_pkg::MODE_RAMP) begin
								if (ramp_end)
									mode_q <= sdg_pkg::MODE_IDLE;
								else
									ridx_q <= ridx_q - 8'd1;
							end
						end
					end
					sdg_pkg::OP_RUN: begin
						steps_q <= '0;
						dir_q   <= !val_q[31];
						mode_q  <= sdg_pkg::MODE_RUN;
					end
					sdg_pkg::OP_STOP: begin
						steps_q <= '0;
						mode_q  <= sdg_pkg::MODE_IDLE;
					end
					sdg_pkg::OP_SET_POS: pos_q <= val_q;
					sdg_pkg::OP_SET_SPEED: begin
						if (!sval_pos)
							err_q <= 1'b1;
					end
					sdg_pkg::OP_RAMP: begin
						if (speed_q == '0 || rstart_q == '0) begin
							mode_q <= sdg_pkg::MODE_IDLE;
						end else begin
							mode_q <= sdg_pkg::MODE_RAMP;
							ridx_q <= rstart_q - 8'd1;
						end
					end
					default: ; // moves finish in the next cycle
				endcase
			end

			if (cmd.move_apply) begin
				dir_q   <= !diff_q[32];
				steps_q <= mag;
				mode_q  <= (mag != '0) ? sdg_pkg::MODE_MOVE : sdg_pkg::MODE_IDLE;
			end

			if (cmd.spd_load) begin
				interval_q <= 32'(div_quo);
				speed_q    <= new_spd_q;
			end

			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			diff_q    <= {val_q[31], val_q} - sub_b;
			new_spd_q <= spd_sat;
		end
		if (cmd.ramp_chk)
			new_spd_q <= 16'(rpm);
		if (cmd.out_load)
			out_data_q <= {4'd0, err_q, (mode_q != sdg_pkg::MODE_IDLE), steps_q, pos_q,
			               dir_q ^ inv_q, pulse_q};
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_move_has_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == sdg_pkg::MODE_MOVE) |-> (steps_q != '0))
		else $error("counted move active with no steps left");

	a_speed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(speed_q != '0) |=> (speed_q != '0))
		else $error("speed returned to zero");

	a_step_clears_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && op_q == sdg_pkg::OP_TICK && fire) |=> (elapsed_q == '0 && pulse_q))
		else $error("step issued without clearing the tick counter");

endmodule

// ===== src/sdg_ctrl.sv =====
`timescale 1ns / 1ps

module sdg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sdg_pkg::sts_t sts,
	output sdg_pkg::cmd_t cmd
);

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_EXEC   = 11'b000_0000_0010,
		ST_MOVE   = 11'b000_0000_0100,
		ST_RSTART = 11'b000_0000_1000,
		ST_RWAIT  = 11'b000_0001_0000,
		ST_RCHK   = 11'b000_0010_0000,
		ST_PSTART = 11'b000_0100_0000,
		ST_PWAIT  = 11'b000_1000_0000,
		ST_SSTART = 11'b001_0000_0000,
		ST_SWAIT  = 11'b010_0000_0000,
		ST_FIN    = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.go_move)
					state_d = ST_MOVE;
				else if (sts.go_ramp)
					state_d = ST_RSTART;
				else if (sts.go_speed)
					state_d = ST_PSTART;
				else
					state_d = ST_FIN;
			end
			ST_MOVE: begin
				cmd.move_apply = 1'b1;
				state_d        = ST_FIN;
			end
			ST_RSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = sdg_pkg::DSEL_RAMP;
				state_d       = ST_RWAIT;
			end
			ST_RWAIT: begin
				cmd.div_sel = sdg_pkg::DSEL_RAMP;
				if (sts.div_done)
					state_d = ST_RCHK;
			end
			ST_RCHK: begin
				cmd.ramp_chk = 1'b1;
				state_d      = sts.go_speed ? ST_PSTART : ST_FIN;
			end
			ST_PSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = sdg_pkg::DSEL_PRE;
				state_d       = ST_PWAIT;
			end
			ST_PWAIT: begin
				cmd.div_sel = sdg_pkg::DSEL_PRE;
				if (sts.div_done)
					state_d = ST_SSTART;
			end
			ST_SSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = sdg_pkg::DSEL_SPD;
				state_d       = ST_SWAIT;
			end
			ST_SWAIT: begin
				cmd.div_sel = sdg_pkg::DSEL_SPD;
				if (sts.div_done) begin
					cmd.spd_load = 1'b1;
					state_d      = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule
